/* hdl/request_frame_parser_crc32_macros.svh */
// ============================================================================
// request_frame_parser_crc32 assertion macros
// Shared concurrent assertion forms for the frame parser checkers.
// ============================================================================
`ifndef REQUEST_FRAME_PARSER_CRC32_MACROS_SVH
`define REQUEST_FRAME_PARSER_CRC32_MACROS_SVH

// same-cycle implication, quiet during reset
`define RFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define RFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rfp_pkg.sv */
// ============================================================================
// rfp_pkg
// Types, codes and the CRC-32 byte step shared by the request frame parser.
// ============================================================================
package rfp_pkg;

    localparam int APB_ADDR_W = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_MSG_TYPE = 2'd2;

    localparam logic [15:0] TIMEOUT_RST  = 16'd100;
    localparam logic [7:0]  VERSION_RST  = 8'h01;
    localparam logic [7:0]  MSG_TYPE_RST = 8'h20;

    localparam logic [7:0] SOF0_BYTE = 8'hA5;
    localparam logic [7:0] SOF1_BYTE = 8'h5A;
    localparam logic [7:0] EOF0_BYTE = 8'h0D;
    localparam logic [7:0] EOF1_BYTE = 8'h0A;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    localparam logic [3:0] ST_NONE    = 4'd0;
    localparam logic [3:0] ST_PENDING = 4'd1;
    localparam logic [3:0] ST_OK      = 4'd2;
    localparam logic [3:0] ST_TIMEOUT = 4'd3;
    localparam logic [3:0] ST_VERSION = 4'd4;
    localparam logic [3:0] ST_TYPE    = 4'd5;
    localparam logic [3:0] ST_LENGTH  = 4'd6;
    localparam logic [3:0] ST_EOF     = 4'd7;
    localparam logic [3:0] ST_CRC     = 4'd8;

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_SOF1   = 14'b00000000000010,
        PH_VER    = 14'b00000000000100,
        PH_TYPE   = 14'b00000000001000,
        PH_SEQ_LO = 14'b00000000010000,
        PH_SEQ_HI = 14'b00000000100000,
        PH_LEN_LO = 14'b00000001000000,
        PH_LEN_HI = 14'b00000010000000,
        PH_CRC0   = 14'b00000100000000,
        PH_CRC1   = 14'b00001000000000,
        PH_CRC2   = 14'b00010000000000,
        PH_CRC3   = 14'b00100000000000,
        PH_EOF0   = 14'b01000000000000,
        PH_EOF1   = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] seq_out;
        logic        frame_busy;
    } out_item_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0]  expected_version;
        logic [7:0]  expected_msg_type;
    } cfg_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/rfp_cfg_regs.sv */
// ============================================================================
// rfp_cfg_regs
// APB register file: timeout and expected version / message type.
// ============================================================================
module rfp_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output rfp_pkg::cfg_t                   cfg
);
    import rfp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms        <= TIMEOUT_RST;
            cfg_reg.expected_version  <= VERSION_RST;
            cfg_reg.expected_msg_type <= MSG_TYPE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TIMEOUT:  cfg_reg.timeout_ms        <= pwdata[15:0];
                REG_VERSION:  cfg_reg.expected_version  <= pwdata[7:0];
                REG_MSG_TYPE: cfg_reg.expected_msg_type <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.timeout_ms};
            REG_VERSION:  prdata = {24'd0, cfg_reg.expected_version};
            REG_MSG_TYPE: prdata = {24'd0, cfg_reg.expected_msg_type};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/rfp_parser.sv */
// ============================================================================
// rfp_parser
// Frame state, CRC accumulator and per-item next-state / result logic.
// ============================================================================
module rfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  rfp_pkg::in_item_t item,
    input  rfp_pkg::cfg_t     cfg,
    output rfp_pkg::out_item_t result
);
    import rfp_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [15:0] seq_reg,     seq_next;
    logic [15:0] len_reg,     len_next;
    logic [31:0] crc_run_reg, crc_run_next;
    logic [31:0] crc_rx_reg,  crc_rx_next;
    logic [31:0] last_reg,    last_next;
    logic        active_reg,  active_next;

    logic [7:0]  b;
    logic [31:0] gap;
    logic        expired;
    logic [31:0] crc_upd;
    logic [15:0] len_full;
    logic        restart, clear, acc;
    phase_t      acc_phase;
    logic [3:0]  status;
    logic [15:0] seq_done;

    assign b        = item.data_byte;
    assign gap      = item.now_ms - last_reg;
    assign expired  = gap >= {16'd0, cfg.timeout_ms};
    assign crc_upd  = crc32_byte(crc_run_reg, b);
    assign len_full = {b, len_reg[7:0]};

    always_comb begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        crc_run_next = crc_run_reg;
        crc_rx_next  = crc_rx_reg;
        last_next    = last_reg;
        active_next  = active_reg;
        restart      = 1'b0;
        clear        = 1'b0;
        acc          = 1'b0;
        acc_phase    = phase_reg;
        status       = ST_NONE;
        seq_done     = '0;

        if (item.req_type == REQ_CHECK) begin
            if (!active_reg) begin
                status = ST_NONE;
            end else if (expired) begin
                clear  = 1'b1;
                status = ST_TIMEOUT;
            end else begin
                status = ST_PENDING;
            end
        end else if (active_reg && expired) begin
            restart = 1'b1;
            status  = ST_TIMEOUT;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (b == SOF0_BYTE) begin
                        restart = 1'b1;
                        status  = ST_PENDING;
                    end
                end
                PH_SOF1: begin
                    if (b == SOF1_BYTE) begin
                        crc_run_next = CRC_INIT;
                        acc          = 1'b1;
                        acc_phase    = PH_VER;
                        status       = ST_PENDING;
                    end else begin
                        restart = 1'b1;
                        status  = (b == SOF0_BYTE) ? ST_PENDING : ST_NONE;
                    end
                end
                PH_VER: begin
                    if (b != cfg.expected_version) begin
                        restart = 1'b1;
                        status  = ST_VERSION;
                    end else begin
                        crc_run_next = crc_upd;
                        acc          = 1'b1;
                        acc_phase    = PH_TYPE;
                        status       = ST_PENDING;
                    end
                end
                PH_TYPE: begin
                    if (b != cfg.expected_msg_type) begin
                        restart = 1'b1;
                        status  = ST_TYPE;
                    end else begin
                        crc_run_next = crc_upd;
                        acc          = 1'b1;
                        acc_phase    = PH_SEQ_LO;
                        status       = ST_PENDING;
                    end
                end
                PH_SEQ_LO: begin
                    seq_next     = {8'd0, b};
                    crc_run_next = crc_upd;
                    acc          = 1'b1;
                    acc_phase    = PH_SEQ_HI;
                    status       = ST_PENDING;
                end
                PH_SEQ_HI: begin
                    seq_next     = {b, seq_reg[7:0]};
                    crc_run_next = crc_upd;
                    acc          = 1'b1;
                    acc_phase    = PH_LEN_LO;
                    status       = ST_PENDING;
                end
                PH_LEN_LO: begin
                    len_next     = {8'd0, b};
                    crc_run_next = crc_upd;
                    acc          = 1'b1;
                    acc_phase    = PH_LEN_HI;
                    status       = ST_PENDING;
                end
                PH_LEN_HI: begin
                    if (len_full != 16'd0) begin
                        restart = 1'b1;
                        status  = ST_LENGTH;
                    end else begin
                        len_next     = len_full;
                        crc_run_next = crc_upd;
                        acc          = 1'b1;
                        acc_phase    = PH_CRC0;
                        status       = ST_PENDING;
                    end
                end
                PH_CRC0: begin
                    crc_rx_next = {24'd0, b};
                    acc         = 1'b1;
                    acc_phase   = PH_CRC1;
                    status      = ST_PENDING;
                end
                PH_CRC1: begin
                    crc_rx_next = {16'd0, b, crc_rx_reg[7:0]};
                    acc         = 1'b1;
                    acc_phase   = PH_CRC2;
                    status      = ST_PENDING;
                end
                PH_CRC2: begin
                    crc_rx_next = {8'd0, b, crc_rx_reg[15:0]};
                    acc         = 1'b1;
                    acc_phase   = PH_CRC3;
                    status      = ST_PENDING;
                end
                PH_CRC3: begin
                    crc_rx_next = {b, crc_rx_reg[23:0]};
                    acc         = 1'b1;
                    acc_phase   = PH_EOF0;
                    status      = ST_PENDING;
                end
                PH_EOF0: begin
                    if (b != EOF0_BYTE) begin
                        restart = 1'b1;
                        status  = ST_EOF;
                    end else begin
                        acc       = 1'b1;
                        acc_phase = PH_EOF1;
                        status    = ST_PENDING;
                    end
                end
                PH_EOF1: begin
                    if (b != EOF1_BYTE) begin
                        restart = 1'b1;
                        status  = ST_EOF;
                    end else if ((crc_run_reg ^ CRC_INIT) != crc_rx_reg) begin
                        restart = 1'b1;
                        status  = ST_CRC;
                    end else begin
                        seq_done = seq_reg;
                        clear    = 1'b1;
                        status   = ST_OK;
                    end
                end
                default: begin
                    restart = 1'b1;
                    status  = ST_NONE;
                end
            endcase
        end

        if (acc) begin
            phase_next  = acc_phase;
            active_next = 1'b1;
            last_next   = item.now_ms;
        end

        if (clear || restart) begin
            phase_next   = PH_IDLE;
            seq_next     = '0;
            len_next     = '0;
            crc_run_next = '0;
            crc_rx_next  = '0;
            last_next    = '0;
            active_next  = 1'b0;
        end

        // an A5 that ends a frame attempt opens the next candidate
        if (restart && (b == SOF0_BYTE)) begin
            phase_next  = PH_SOF1;
            active_next = 1'b1;
            last_next   = item.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            seq_reg     <= '0;
            len_reg     <= '0;
            crc_run_reg <= '0;
            crc_rx_reg  <= '0;
            last_reg    <= '0;
            active_reg  <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            crc_run_reg <= crc_run_next;
            crc_rx_reg  <= crc_rx_next;
            last_reg    <= last_next;
            active_reg  <= active_next;
        end
    end

    assign result.status     = status;
    assign result.seq_out    = seq_done;
    assign result.frame_busy = active_next;

endmodule

/* hdl/request_frame_parser_crc32.sv */
// ============================================================================
// request_frame_parser_crc32
// Byte-serial parser for the 14-byte request frame with CRC-32 check.
// ============================================================================
//  channel  dir  handshake        payload
//  s_       in   s_valid/s_ready  rfp_pkg::in_item_t  (req_type, data_byte, now_ms)
//  m_       out  m_valid/m_ready  rfp_pkg::out_item_t (status, seq_out, frame_busy)
//  apb      in   psel/penable     timeout_ms, expected_version, expected_msg_type
//
//  One transaction per cycle with m_ready high; m_valid comes from the result register.
//  The item register feeds the parser step; the parser updates state and the
//  result register in the same cycle.
//  Reset (aresetn low, synchronous) empties both registers and idles the parser.
//  An m_ stall holds the result; a new item lands in the item register only if empty.
// ============================================================================
module request_frame_parser_crc32 (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rfp_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rfp_pkg::out_item_t              m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rfp_pkg::*;

    in_item_t   item_reg;
    logic       item_vld_reg;
    out_item_t  res_reg;
    logic       res_vld_reg;
    out_item_t  result;
    cfg_t       cfg;
    logic       step;
    logic       s_take;

    assign step    = item_vld_reg & (~res_vld_reg | m_ready);
    assign s_ready = ~item_vld_reg | step;
    assign s_take  = s_valid & s_ready;

    rfp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            if (s_take) begin
                item_vld_reg <= 1'b1;
            end else if (step) begin
                item_vld_reg <= 1'b0;
            end
            if (step) begin
                res_vld_reg <= 1'b1;
            end else if (m_ready) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= s_data;
        end
        if (step) begin
            res_reg <= result;
        end
    end

    assign m_valid = res_vld_reg;
    assign m_data  = res_reg;

endmodule

/* hdl/rfp_checker.sv */
// ============================================================================
// rfp_checker
// Port-level checks on the result channel of the frame parser.
// ============================================================================
`include "request_frame_parser_crc32_macros.svh"

module rfp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  rfp_pkg::out_item_t              m_data
);
    import rfp_pkg::*;

    logic m_stall;
    logic m_ok;
    logic m_not_ok;
    logic m_pend;

    assign m_stall  = m_valid && !m_ready;
    assign m_ok     = m_valid && (m_data.status == ST_OK);
    assign m_not_ok = m_valid && (m_data.status != ST_OK);
    assign m_pend   = m_valid && (m_data.status == ST_PENDING);

    // stalled result holds
    `RFP_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_valid && $stable(m_data), "result moved")

    // a completed frame leaves the parser idle
    `RFP_ASSERT_NOW(a_ok_idle, aclk, aresetn, m_ok, !m_data.frame_busy, "ok with frame busy")

    // sequence only reported on success
    `RFP_ASSERT_NOW(a_seq_zero, aclk, aresetn, m_not_ok, m_data.seq_out == 16'd0, "seq without ok")

    // pending always means a candidate is open
    `RFP_ASSERT_NOW(a_pend_busy, aclk, aresetn, m_pend, m_data.frame_busy, "pending while idle")

endmodule

bind request_frame_parser_crc32 rfp_checker u_rfp_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: request frame parser testbench
// Drives bytes and timeout checks with millisecond stamps into the parser and
// keeps its own model of the frame state machine, CRC and gap timer to predict
// every result. Directed frames cover start bytes, field errors and timeouts.
// Random frames, some with one injected fault, run under several register
// settings with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;   // unmapped index, writes are dropped
    localparam int         IDLE_LIMIT = 5000;

    typedef enum int {
        FAULT_NONE,
        FAULT_SOF1,
        FAULT_VERSION,
        FAULT_TYPE,
        FAULT_LENGTH,
        FAULT_CRC,
        FAULT_EOF0,
        FAULT_EOF1,
        FAULT_TRUNCATE
    } frame_fault_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // parser model
    cfg_t        model_cfg;
    phase_t      ph;
    logic [15:0] seq_acc;
    logic [15:0] len_acc;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    logic [31:0] last_ms;
    logic        in_frame;

    out_item_t   result_q[$];
    logic [31:0] clock_ms    = '0;
    bit          steady      = 1'b0;   // no idling on either channel
    int          items_sent  = 0;
    int          n_errors    = 0;
    int          n_ok        = 0;
    int          n_timeout   = 0;
    int          n_fault     = 0;
    int          idle_cycles = 0;
    int          stall_cnt   = 0;

    request_frame_parser_crc32 i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // reflected CRC-32, data bit fed into the feedback term
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ b[k]}});
        end
        return r;
    endfunction

    function automatic void parser_clear();
        ph       = PH_IDLE;
        seq_acc  = '0;
        len_acc  = '0;
        crc_acc  = '0;
        crc_rx   = '0;
        last_ms  = '0;
        in_frame = 1'b0;
    endfunction

    function automatic void parser_restart(input logic [7:0] b, input logic [31:0] now);
        parser_clear();
        if (b == SOF0_BYTE) begin
            ph       = PH_SOF1;
            in_frame = 1'b1;
            last_ms  = now;
        end
    endfunction

    function automatic void advance(input phase_t nxt, input logic [31:0] now);
        ph       = nxt;
        in_frame = 1'b1;
        last_ms  = now;
    endfunction

    function automatic out_item_t parse_step(input in_item_t it);
        out_item_t   res;
        logic [7:0]  b;
        logic [31:0] now;
        logic        late;
        b    = it.data_byte;
        now  = it.now_ms;
        res  = '0;
        late = in_frame && ((now - last_ms) >= {16'd0, model_cfg.timeout_ms});
        if (it.req_type == REQ_CHECK) begin
            if (!in_frame) begin
                res.status = ST_NONE;
            end else if (late) begin
                parser_clear();
                res.status = ST_TIMEOUT;
            end else begin
                res.status = ST_PENDING;
            end
        end else if (late) begin
            parser_restart(b, now);
            res.status = ST_TIMEOUT;
        end else begin
            res.status = ST_PENDING;
            case (ph)
                PH_IDLE: begin
                    if (b == SOF0_BYTE) parser_restart(b, now);
                    else res.status = ST_NONE;
                end
                PH_SOF1: begin
                    if (b == SOF1_BYTE) begin
                        crc_acc = CRC_INIT;
                        advance(PH_VER, now);
                    end else begin
                        parser_restart(b, now);
                        if (b != SOF0_BYTE) res.status = ST_NONE;
                    end
                end
                PH_VER: begin
                    if (b != model_cfg.expected_version) begin
                        parser_restart(b, now);
                        res.status = ST_VERSION;
                    end else begin
                        crc_acc = crc_step(crc_acc, b);
                        advance(PH_TYPE, now);
                    end
                end
                PH_TYPE: begin
                    if (b != model_cfg.expected_msg_type) begin
                        parser_restart(b, now);
                        res.status = ST_TYPE;
                    end else begin
                        crc_acc = crc_step(crc_acc, b);
                        advance(PH_SEQ_LO, now);
                    end
                end
                PH_SEQ_LO: begin
                    seq_acc = {8'd0, b};
                    crc_acc = crc_step(crc_acc, b);
                    advance(PH_SEQ_HI, now);
                end
                PH_SEQ_HI: begin
                    seq_acc[15:8] = b;
                    crc_acc = crc_step(crc_acc, b);
                    advance(PH_LEN_LO, now);
                end
                PH_LEN_LO: begin
                    len_acc = {8'd0, b};
                    crc_acc = crc_step(crc_acc, b);
                    advance(PH_LEN_HI, now);
                end
                PH_LEN_HI: begin
                    len_acc[15:8] = b;
                    crc_acc = crc_step(crc_acc, b);
                    if (len_acc != 16'd0) begin
                        parser_restart(b, now);
                        res.status = ST_LENGTH;
                    end else begin
                        advance(PH_CRC0, now);
                    end
                end
                PH_CRC0: begin
                    crc_rx = {24'd0, b};
                    advance(PH_CRC1, now);
                end
                PH_CRC1: begin
                    crc_rx[15:8] = b;
                    advance(PH_CRC2, now);
                end
                PH_CRC2: begin
                    crc_rx[23:16] = b;
                    advance(PH_CRC3, now);
                end
                PH_CRC3: begin
                    crc_rx[31:24] = b;
                    advance(PH_EOF0, now);
                end
                PH_EOF0: begin
                    if (b != EOF0_BYTE) begin
                        parser_restart(b, now);
                        res.status = ST_EOF;
                    end else begin
                        advance(PH_EOF1, now);
                    end
                end
                PH_EOF1: begin
                    if (b != EOF1_BYTE) begin
                        parser_restart(b, now);
                        res.status = ST_EOF;
                    end else if (~crc_acc != crc_rx) begin
                        parser_restart(b, now);
                        res.status = ST_CRC;
                    end else begin
                        res.status  = ST_OK;
                        res.seq_out = seq_acc;
                        parser_clear();
                    end
                end
                default: begin
                    parser_restart(b, now);
                    res.status = ST_NONE;
                end
            endcase
        end
        res.frame_busy = in_frame;
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ms between items: mostly inside the limit, some right at it or past it
    function automatic logic [31:0] pick_delta();
        logic [31:0] tmo;
        int          r;
        tmo = {16'd0, model_cfg.timeout_ms};
        r   = $urandom_range(0, 99);
        if (tmo == 0) return $urandom_range(0, 3);
        if (r < 85) return $urandom_range(0, tmo - 1);
        if (r < 90) return tmo - 1;
        if (r < 96) return tmo + $urandom_range(0, 2);
        return $urandom();
    endfunction

    function automatic logic [7:0] corrupt(input logic [7:0] good);
        if (good != SOF0_BYTE && $urandom_range(0, 2) == 0) return SOF0_BYTE;
        return good ^ 8'($urandom_range(1, 255));
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] b);
        in_item_t it;
        int       gap;
        it.req_type  = kind;
        it.data_byte = b;
        it.now_ms    = clock_ms;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        result_q.push_back(parse_step(it));
        items_sent++;
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic [31:0] delta);
        clock_ms += delta;
        send_item(REQ_BYTE, b);
    endtask

    task automatic poll_timeout(input logic [31:0] delta);
        clock_ms += delta;
        send_item(REQ_CHECK, 8'($urandom()));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TIMEOUT:  model_cfg.timeout_ms        = value[15:0];
            REG_VERSION:  model_cfg.expected_version  = value[7:0];
            REG_MSG_TYPE: model_cfg.expected_msg_type = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] tmo, input logic [7:0] ver,
                                  input logic [7:0] typ);
        wait_idle();
        reg_write(REG_TIMEOUT, {16'd0, tmo});
        reg_write(REG_VERSION, {24'd0, ver});
        reg_write(REG_MSG_TYPE, {24'd0, typ});
    endtask

    task automatic send_frame(input logic [15:0] seq, input frame_fault_t fault,
                              input bit jitter);
        logic [7:0]  fb [14];
        logic [31:0] crc;
        int          n_bytes;
        int          pos;
        fb[0] = SOF0_BYTE;
        fb[1] = SOF1_BYTE;
        fb[2] = model_cfg.expected_version;
        fb[3] = model_cfg.expected_msg_type;
        fb[4] = seq[7:0];
        fb[5] = seq[15:8];
        fb[6] = 8'h00;
        fb[7] = 8'h00;
        crc = CRC_INIT;
        for (int i = 2; i < 8; i++) crc = crc_step(crc, fb[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++) fb[8 + i] = crc[8*i +: 8];
        fb[12] = EOF0_BYTE;
        fb[13] = EOF1_BYTE;
        n_bytes = 14;
        case (fault)
            FAULT_SOF1:    fb[1] = corrupt(fb[1]);
            FAULT_VERSION: fb[2] = corrupt(fb[2]);
            FAULT_TYPE:    fb[3] = corrupt(fb[3]);
            FAULT_LENGTH: begin
                pos = $urandom_range(6, 7);
                fb[pos] = corrupt(fb[pos]);
            end
            FAULT_CRC: begin
                // hit either a sequence byte or a CRC byte
                pos = $urandom_range(0, 5);
                pos = (pos < 2) ? pos + 4 : pos + 6;
                fb[pos] = corrupt(fb[pos]);
            end
            FAULT_EOF0:     fb[12] = corrupt(fb[12]);
            FAULT_EOF1:     fb[13] = corrupt(fb[13]);
            FAULT_TRUNCATE: n_bytes = $urandom_range(1, 13);
            default: ;
        endcase
        for (int i = 0; i < n_bytes; i++) begin
            if (jitter && $urandom_range(0, 99) < 6) poll_timeout(pick_delta());
            feed_byte(fb[i], jitter ? pick_delta() : 32'd1);
        end
    endtask

    task automatic run_traffic(input int n_items);
        int           stop_at;
        frame_fault_t fault;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 45) begin
                fault = FAULT_NONE;
            end else begin
                fault = frame_fault_t'($urandom_range(FAULT_SOF1, FAULT_TRUNCATE));
            end
            send_frame(16'($urandom()), fault, 1'b1);
            if ($urandom_range(0, 99) < 25) begin
                repeat ($urandom_range(1, 3)) feed_byte(8'($urandom()), pick_delta());
            end
            if ($urandom_range(0, 99) < 10) steady = ~steady;
        end
        steady = 1'b0;
    endtask

    task automatic test_good_frame();
        clock_ms = 32'hFFFF_FFF4;   // stamps roll over inside the frame
        send_frame(16'hFFFF, FAULT_NONE, 1'b0);
        poll_timeout(32'd5);
    endtask

    task automatic test_start_and_field_errors();
        feed_byte(SOF0_BYTE, 1);
        feed_byte(SOF0_BYTE, 1);                 // repeated start byte restarts
        feed_byte(SOF1_BYTE, 1);
        feed_byte(SOF0_BYTE, 1);                 // bad version, kept as new start
        feed_byte(SOF1_BYTE, 1);
        feed_byte(model_cfg.expected_version, 1);
        feed_byte(model_cfg.expected_msg_type ^ 8'hFF, 1);
        feed_byte(8'hFF, 1);                     // idle, ignored
        feed_byte(SOF0_BYTE, 1);
        feed_byte(8'h00, 1);                     // broken second start byte
    endtask

    task automatic test_timeouts();
        logic [31:0] tmo;
        tmo = {16'd0, model_cfg.timeout_ms};
        feed_byte(SOF0_BYTE, 1);
        poll_timeout(tmo - 1);
        poll_timeout(1);                         // gap reaches the limit
        poll_timeout(1);
        feed_byte(SOF0_BYTE, 1);
        feed_byte(SOF1_BYTE, 1);
        feed_byte(SOF0_BYTE, tmo + 50);          // late start byte opens a new frame
        feed_byte(SOF1_BYTE, 0);
        feed_byte(8'h3C, tmo);
    endtask

    task automatic test_register_settings();
        wait_idle();
        reg_write(REG_SPARE, 32'hFFFF_FFFF);
        apply_settings(16'd1, 8'h00, 8'h00);
        run_traffic(50);
        apply_settings(16'hFFFF, 8'hFF, 8'hFF);
        run_traffic(50);
        apply_settings(16'd0, SOF0_BYTE, SOF1_BYTE);   // every open frame expires
        run_traffic(30);
        apply_settings(16'($urandom_range(2, 300)), 8'($urandom()), 8'($urandom()));
        run_traffic(50);
        apply_settings(TIMEOUT_RST, VERSION_RST, MSG_TYPE_RST);
    endtask

    task automatic test_random_traffic();
        clock_ms = $urandom();
        run_traffic(200);
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: result with none expected: status %0d seq %04h busy %0b",
                         $time, m_data.status, m_data.seq_out, m_data.frame_busy);
                n_errors++;
            end else begin
                want = result_q.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    n_errors++;
                end
                if (m_data.seq_out !== want.seq_out) begin
                    $display("%0t: seq_out expected %04h actual %04h",
                             $time, want.seq_out, m_data.seq_out);
                    n_errors++;
                end
                if (m_data.frame_busy !== want.frame_busy) begin
                    $display("%0t: frame_busy expected %0b actual %0b",
                             $time, want.frame_busy, m_data.frame_busy);
                    n_errors++;
                end
                if (want.status == ST_OK) n_ok++;
                else if (want.status == ST_TIMEOUT) n_timeout++;
                else if (want.status >= ST_VERSION) n_fault++;
            end
        end
        if (stall_cnt == 0) stall_cnt = idle_len() + 1;
        stall_cnt--;
        m_ready <= (stall_cnt == 0);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL request_frame_parser_crc32");
            $finish;
        end
    end

    initial begin
        parser_clear();
        model_cfg.timeout_ms        = TIMEOUT_RST;
        model_cfg.expected_version  = VERSION_RST;
        model_cfg.expected_msg_type = MSG_TYPE_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_frame();
        test_start_and_field_errors();
        test_timeouts();
        test_register_settings();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d byte and timeout-check transactions over five register settings.",
                 items_sent);
        $display("Frames completed %0d, timeouts %0d, field/EOF/CRC errors %0d.",
                 n_ok, n_timeout, n_fault);
        if (n_errors == 0) begin
            $display("PASS request_frame_parser_crc32");
        end else begin
            $display("FAIL request_frame_parser_crc32");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/rfp_pkg.sv
hdl/rfp_cfg_regs.sv
hdl/rfp_parser.sv
hdl/request_frame_parser_crc32.sv
hdl/rfp_checker.sv
tb/sv/tb_top.sv
